// ===== design/assert_macros.svh =====
// Assertion macros used by the byte_code_cpu_step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCC_NEVER(lbl, clk, rst_n, cond, msg) \
  `BCC_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  localparam int MemDepthDef = 256;
  localparam int NumRegsDef  = 4;

  localparam int DataW     = 8;
  localparam int InTdataW  = 16;
  localparam int InTuserW  = 2;
  localparam int OutTdataW = 40;
  localparam int OutTuserW = 3;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALTED  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_STOPPED = 2'd3
  } status_e;

  localparam logic [7:0] OP_MOV   = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_PRN   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_CMP   = 8'd5;
  localparam logic [7:0] OP_JEQ   = 8'd6;
  localparam logic [7:0] OP_JMP   = 8'd7;
  localparam logic [7:0] OP_STORE = 8'd8;
  localparam logic [7:0] OP_LOAD  = 8'd9;
  localparam logic [7:0] OP_HLT   = 8'd255;

  // Byte modulo a constant depth d of 2 to 256. The caller passes recip = 65536 / d + 1,
  // which makes the quotient (v * recip) >> 16 exact for every byte value.
  function automatic logic [7:0] wrap8(input logic [7:0] v, input logic [8:0] d,
                                       input logic [16:0] recip);
    logic [24:0] p;
    logic [16:0] qd;
    p  = 25'(v) * 25'(recip);
    qd = 17'(p[23:16]) * 17'(d);
    return v - qd[7:0];
  endfunction

endpackage

// ===== design/bcc_ram.sv =====
module bcc_ram #(
  parameter int Depth = bcc_pkg::MemDepthDef,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [bcc_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [bcc_pkg::DataW-1:0] rdata_o
);

  logic [bcc_pkg::DataW-1:0] mem_q [Depth];
  logic [Depth-1:0]          vld_q;
  logic [bcc_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  // An entry never written reads as zero, so reset needs no sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/byte_code_cpu_step.sv =====
// Channel   Direction  Signals                        Contents
// command   in         s_axis_tvalid/tready/tdata/tuser  one command with its operands
// result    out        m_axis_tvalid/tready/tdata/tuser  one result beat per command
//
// The result beat is registered in the output state, which a write, a restart or a
// step while stopped reaches directly, a read through S_MEMRD and an executed step
// through S_FA to S_EXEC; the next command can be taken as the beat is presented.
// The instruction steps follow from the single read port of main memory (opcode, two
// operands, load data) and the registered register-file read.
// Reset clears the state at once through per-entry valid bits; there is no clearing pass.
// A stalled result beat holds in the output register while the next command is fetched.
`include "assert_macros.svh"

module byte_code_cpu_step #(
  parameter int MEM_DEPTH = bcc_pkg::MemDepthDef,
  parameter int NUM_REGS  = bcc_pkg::NumRegsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] address, [15:8] data
  input  logic [bcc_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [bcc_pkg::InTuserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] pc_out, [15:8] opcode, [17:16] print_reg, [25:18] print_value,
  // [33:26] read_data, [34] zero_out, [39:35] zero
  output logic [bcc_pkg::OutTdataW-1:0] m_axis_tdata,
  // [1:0] status, [2] print_valid
  output logic [bcc_pkg::OutTuserW-1:0] m_axis_tuser
);

  localparam int MemAw    = $clog2(MEM_DEPTH);
  localparam int RegAw    = $clog2(NUM_REGS);
  localparam int MemRecip = 65536 / MEM_DEPTH + 1;
  localparam int RegRecip = 65536 / NUM_REGS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MEMRD, S_FA, S_FB, S_REGA, S_EXEC, S_OUT
  } state_e;

  function automatic logic [MemAw-1:0] maddr(input logic [7:0] a);
    logic [7:0] w;
    w = bcc_pkg::wrap8(a, 9'(MEM_DEPTH), 17'(MemRecip));
    return w[MemAw-1:0];
  endfunction

  function automatic logic [RegAw-1:0] ridx(input logic [7:0] a);
    logic [7:0] w;
    w = bcc_pkg::wrap8(a, 9'(NUM_REGS), 17'(RegRecip));
    return w[RegAw-1:0];
  endfunction

  state_e           state_q;
  logic [7:0]       pc_q;
  logic             run_q;
  logic             zero_q;
  logic [7:0]       opc_q;
  logic [7:0]       op1_q;
  logic [7:0]       op2_q;
  logic [7:0]       ra_q;
  bcc_pkg::status_e res_status_q;
  logic [7:0]       res_opc_q;
  logic             res_pv_q;
  logic [1:0]       res_preg_q;
  logic [7:0]       res_pval_q;
  logic [7:0]       res_rdata_q;
  logic             m_tvalid_q;
  logic [bcc_pkg::OutTdataW-1:0] m_tdata_q;
  logic [bcc_pkg::OutTuserW-1:0] m_tuser_q;

  logic          in_accept;
  bcc_pkg::cmd_e in_cmd;
  logic [7:0]    in_addr;
  logic [7:0]    in_data;

  logic             mem_we;
  logic [MemAw-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [MemAw-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic             reg_we;
  logic [RegAw-1:0] reg_waddr;
  logic [RegAw-1:0] reg_raddr;
  logic [7:0]       reg_rdata;

  logic [7:0]       ex_npc;
  bcc_pkg::status_e ex_status;
  logic             ex_run;
  logic             ex_zero;
  logic             ex_reg_we;
  logic [7:0]       ex_reg_wdata;
  logic             ex_mem_we;
  logic             ex_pv;
  logic [7:0]       ex_pval;
  logic [7:0]       ex_a8;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = bcc_pkg::cmd_e'(s_axis_tuser);
  assign in_addr       = s_axis_tdata[7:0];
  assign in_data       = s_axis_tdata[15:8];

  // Execute stage: ra_q holds the first register, reg_rdata the second and mem_rdata
  // the byte at the second operand.
  always_comb begin
    ex_a8        = bcc_pkg::wrap8(op1_q, 9'(NUM_REGS), 17'(RegRecip));
    ex_npc       = pc_q + 8'd3;
    ex_status    = bcc_pkg::ST_OK;
    ex_run       = run_q;
    ex_zero      = zero_q;
    ex_reg_we    = 1'b0;
    ex_reg_wdata = op2_q;
    ex_mem_we    = 1'b0;
    ex_pv        = 1'b0;
    ex_pval      = 8'd0;
    case (opc_q)
      bcc_pkg::OP_MOV: begin
        ex_reg_we = 1'b1;
      end
      bcc_pkg::OP_ADD: begin
        ex_reg_we    = 1'b1;
        ex_reg_wdata = ra_q + reg_rdata;
      end
      bcc_pkg::OP_SUB: begin
        ex_reg_we    = 1'b1;
        ex_reg_wdata = ra_q - reg_rdata;
      end
      bcc_pkg::OP_CMP: begin
        ex_zero = (ra_q == reg_rdata);
      end
      bcc_pkg::OP_JEQ: begin
        ex_npc = zero_q ? op1_q : pc_q + 8'd2;
      end
      bcc_pkg::OP_JMP: begin
        ex_npc = op1_q;
      end
      bcc_pkg::OP_STORE: begin
        ex_mem_we = 1'b1;
      end
      bcc_pkg::OP_LOAD: begin
        ex_reg_we    = 1'b1;
        ex_reg_wdata = mem_rdata;
      end
      bcc_pkg::OP_PRN: begin
        ex_pv   = 1'b1;
        ex_pval = ra_q;
        ex_npc  = pc_q + 8'd2;
      end
      bcc_pkg::OP_HLT: begin
        ex_run    = 1'b0;
        ex_status = bcc_pkg::ST_HALTED;
        ex_npc    = pc_q + 8'd1;
      end
      default: begin
        ex_run    = 1'b0;
        ex_status = bcc_pkg::ST_UNKNOWN;
        ex_npc    = pc_q;
      end
    endcase
  end

  always_comb begin
    mem_raddr = maddr(pc_q);
    mem_we    = 1'b0;
    mem_waddr = maddr(in_addr);
    mem_wdata = in_data;
    reg_raddr = ridx(mem_rdata);
    case (state_q)
      S_IDLE: begin
        if (in_cmd == bcc_pkg::CMD_READ) begin
          mem_raddr = maddr(in_addr);
        end
        mem_we = in_accept && (in_cmd == bcc_pkg::CMD_WRITE);
      end
      S_FA:   mem_raddr = maddr(pc_q + 8'd1);
      S_FB:   mem_raddr = maddr(pc_q + 8'd2);
      S_REGA: mem_raddr = maddr(mem_rdata);
      S_EXEC: begin
        mem_we    = ex_mem_we;
        mem_waddr = maddr(op2_q);
        mem_wdata = ra_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign reg_we    = (state_q == S_EXEC) && ex_reg_we;
  assign reg_waddr = ridx(op1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= 8'd0;
      run_q        <= 1'b1;
      zero_q       <= 1'b0;
      opc_q        <= 8'd0;
      op1_q        <= 8'd0;
      op2_q        <= 8'd0;
      ra_q         <= 8'd0;
      res_status_q <= bcc_pkg::ST_OK;
      res_opc_q    <= 8'd0;
      res_pv_q     <= 1'b0;
      res_preg_q   <= 2'd0;
      res_pval_q   <= 8'd0;
      res_rdata_q  <= 8'd0;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
      m_tuser_q    <= '0;
    end else begin
      // In the output state the beat register is handled below.
      if (m_tvalid_q && m_axis_tready && state_q != S_OUT) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            res_status_q <= bcc_pkg::ST_OK;
            res_opc_q    <= 8'd0;
            res_pv_q     <= 1'b0;
            res_preg_q   <= 2'd0;
            res_pval_q   <= 8'd0;
            res_rdata_q  <= 8'd0;
            case (in_cmd)
              bcc_pkg::CMD_WRITE: state_q <= S_OUT;
              bcc_pkg::CMD_READ:  state_q <= S_MEMRD;
              bcc_pkg::CMD_RESTART: begin
                pc_q    <= in_addr;
                run_q   <= 1'b1;
                state_q <= S_OUT;
              end
              bcc_pkg::CMD_STEP: begin
                if (run_q) begin
                  state_q <= S_FA;
                end else begin
                  res_status_q <= bcc_pkg::ST_STOPPED;
                  state_q      <= S_OUT;
                end
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_MEMRD: begin
          res_rdata_q <= mem_rdata;
          state_q     <= S_OUT;
        end
        S_FA: begin
          opc_q   <= mem_rdata;
          state_q <= S_FB;
        end
        S_FB: begin
          op1_q   <= mem_rdata;
          state_q <= S_REGA;
        end
        S_REGA: begin
          op2_q   <= mem_rdata;
          ra_q    <= reg_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          pc_q         <= ex_npc;
          run_q        <= ex_run;
          zero_q       <= ex_zero;
          res_status_q <= ex_status;
          res_opc_q    <= opc_q;
          res_pv_q     <= ex_pv;
          res_preg_q   <= ex_pv ? ex_a8[1:0] : 2'd0;
          res_pval_q   <= ex_pval;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {5'd0, zero_q, res_rdata_q, res_pval_q, res_preg_q,
                           res_opc_q, pc_q};
            m_tuser_q  <= {res_pv_q, res_status_q};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bcc_ram #(
    .Depth(MEM_DEPTH)
  ) u_main_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bcc_ram #(
    .Depth(NUM_REGS)
  ) u_reg_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (reg_we),
    .waddr_i(reg_waddr),
    .wdata_i(ex_reg_wdata),
    .raddr_i(reg_raddr),
    .rdata_o(reg_rdata)
  );

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  `BCC_ASSERT(a_busy_after_accept, clk_i, rst_ni,
              in_accept |=> !s_axis_tready, "command taken while busy")
  `BCC_ASSERT(a_beat_from_out, clk_i, rst_ni,
              $rose(m_axis_tvalid) |-> $past(state_q == S_OUT), "result beat outside output")
  `BCC_NEVER(a_mem_we_state, clk_i, rst_ni,
             mem_we && state_q != S_IDLE && state_q != S_EXEC, "memory write out of place")
  `BCC_NEVER(a_reg_we_state, clk_i, rst_ni,
             reg_we && state_q != S_EXEC, "register write outside execute")
  `BCC_ASSERT(a_stop_in_exec, clk_i, rst_ni,
              $fell(run_q) |-> $past(state_q == S_EXEC), "machine stopped outside execute")

endmodule

// ===== tb/tb_byte_code_cpu_step.sv =====
module tb_byte_code_cpu_step;

  localparam int ItemsPerPhase = 365;
  localparam int CycleLimit    = 500000;
  localparam int SettleCycles  = 20;

  typedef struct packed {
    bcc_pkg::status_e status;
    logic [7:0]       pc;
    logic [7:0]       opcode;
    logic             prn_valid;
    logic [1:0]       prn_reg;
    logic [7:0]       prn_value;
    logic [7:0]       rd_data;
    logic             zero;
  } cpu_result_t;

  typedef struct packed {
    bcc_pkg::cmd_e    cmd;
    logic [7:0]       addr;
    logic [7:0]       data;
    logic             typed;
    bcc_pkg::status_e status;
    logic [7:0]       pc;
    logic [7:0]       opcode;
    logic [7:0]       rd_data;
  } dir_row_t;

  // Rows with the typed flag set carry their own result; the rest are predicted.
  localparam dir_row_t DirectedRows [27] = '{
    '{bcc_pkg::CMD_READ,    8'd255, 8'd0,   1'b1, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b1, bcc_pkg::ST_UNKNOWN, 8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd255, 8'd255, 1'b1, bcc_pkg::ST_STOPPED, 8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd255, 8'd255, 1'b1, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_READ,    8'd255, 8'd0,   1'b1, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd255},
    '{bcc_pkg::CMD_RESTART, 8'd255, 8'd0,   1'b1, bcc_pkg::ST_OK,      8'd255, 8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b1, bcc_pkg::ST_HALTED,  8'd0,   8'd255, 8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b1, bcc_pkg::ST_STOPPED, 8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd254, bcc_pkg::OP_MOV, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd0,   8'd200, 1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_RESTART, 8'd254, 8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd1,   bcc_pkg::OP_PRN, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd2,   8'd7,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd3,   bcc_pkg::OP_SUB, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd5,   8'd3,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd6,   bcc_pkg::OP_CMP, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd9,   bcc_pkg::OP_JEQ, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd10,  8'd254, 1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_RESTART, 8'd2,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0},
    '{bcc_pkg::CMD_WRITE,   8'd4,   bcc_pkg::OP_ADD, 1'b0, bcc_pkg::ST_OK, 8'd0, 8'd0, 8'd0},
    '{bcc_pkg::CMD_STEP,    8'd0,   8'd0,   1'b0, bcc_pkg::ST_OK,      8'd0,   8'd0,   8'd0}
  };

  localparam logic [7:0] KnownOps [10] = '{
    bcc_pkg::OP_MOV, bcc_pkg::OP_ADD, bcc_pkg::OP_PRN, bcc_pkg::OP_SUB, bcc_pkg::OP_CMP,
    bcc_pkg::OP_JEQ, bcc_pkg::OP_JMP, bcc_pkg::OP_STORE, bcc_pkg::OP_LOAD, bcc_pkg::OP_HLT
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bcc_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic [bcc_pkg::InTuserW-1:0]  s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bcc_pkg::OutTdataW-1:0] m_axis_tdata;
  logic [bcc_pkg::OutTuserW-1:0] m_axis_tuser;

  // Shadow state of the processor.
  logic [7:0] mem_image [256];
  logic [7:0] reg_image [4];
  logic [7:0] pc_image;
  logic       running;
  logic       zflag_image;

  cpu_result_t pending_results [$];
  int          error_count = 0;
  int          items_fed = 0;
  int          cycle_count = 0;
  int          status_count [4] = '{0, 0, 0, 0};
  int          print_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  byte_code_cpu_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      mem_image[i] = 8'd0;
    end
    for (int i = 0; i < 4; i++) begin
      reg_image[i] = 8'd0;
    end
    pc_image    = 8'd0;
    running     = 1'b1;
    zflag_image = 1'b0;
  end

  function automatic cpu_result_t execute_command(bcc_pkg::cmd_e cmd, logic [7:0] addr,
                                                  logic [7:0] data);
    cpu_result_t r;
    logic [7:0]  opc;
    logic [7:0]  op1;
    logic [7:0]  op2;
    logic [7:0]  at1;
    logic [7:0]  at2;
    logic [7:0]  next_pc;
    logic [1:0]  ra;
    logic [1:0]  rb;
    r = '0;
    case (cmd)
      bcc_pkg::CMD_WRITE: begin
        mem_image[addr] = data;
      end
      bcc_pkg::CMD_READ: begin
        r.rd_data = mem_image[addr];
      end
      bcc_pkg::CMD_RESTART: begin
        pc_image = addr;
        running  = 1'b1;
      end
      default: begin
        if (!running) begin
          r.status = bcc_pkg::ST_STOPPED;
        end else begin
          at1     = pc_image + 8'd1;
          at2     = pc_image + 8'd2;
          opc     = mem_image[pc_image];
          op1     = mem_image[at1];
          op2     = mem_image[at2];
          ra      = op1[1:0];
          rb      = op2[1:0];
          next_pc = pc_image + 8'd3;
          r.opcode = opc;
          case (opc)
            bcc_pkg::OP_MOV: reg_image[ra] = op2;
            bcc_pkg::OP_ADD: reg_image[ra] = reg_image[ra] + reg_image[rb];
            bcc_pkg::OP_SUB: reg_image[ra] = reg_image[ra] - reg_image[rb];
            bcc_pkg::OP_CMP: zflag_image = (reg_image[ra] == reg_image[rb]);
            bcc_pkg::OP_JEQ: next_pc = zflag_image ? op1 : at2;
            bcc_pkg::OP_JMP: next_pc = op1;
            bcc_pkg::OP_STORE: mem_image[op2] = reg_image[ra];
            bcc_pkg::OP_LOAD: reg_image[ra] = mem_image[op2];
            bcc_pkg::OP_PRN: begin
              r.prn_valid = 1'b1;
              r.prn_reg   = ra;
              r.prn_value = reg_image[ra];
              next_pc     = at2;
            end
            bcc_pkg::OP_HLT: begin
              running  = 1'b0;
              r.status = bcc_pkg::ST_HALTED;
              next_pc  = at1;
            end
            default: begin
              // An unknown opcode stops the machine where it stands.
              running  = 1'b0;
              r.status = bcc_pkg::ST_UNKNOWN;
              next_pc  = pc_image;
            end
          endcase
          pc_image = next_pc;
        end
      end
    endcase
    r.pc   = pc_image;
    r.zero = zflag_image;
    return r;
  endfunction

  task automatic send_command(bcc_pkg::cmd_e cmd, logic [7:0] addr, logic [7:0] data,
                              bit typed = 1'b0, cpu_result_t golden = '0);
    cpu_result_t want;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    want = execute_command(cmd, addr, data);
    pending_results.push_back(typed ? golden : want);
    status_count[want.status]++;
    if (want.prn_valid) begin
      print_count++;
    end
    items_fed++;
  endtask

  task automatic idle_bus();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // A short program of mostly known opcodes with random operands, then a run of steps.
  task automatic run_program();
    logic [7:0] base;
    logic [7:0] at;
    logic [7:0] opc;
    logic [7:0] op1;
    logic [7:0] op2;
    int         n_instr;
    int         n_steps;
    n_instr = $urandom_range(1, 6);
    base    = 8'($urandom_range(255));
    for (int i = 0; i < n_instr; i++) begin
      opc = KnownOps[$urandom_range(9)];
      if ($urandom_range(11) == 0) begin
        opc = 8'($urandom_range(255));
      end
      op1 = 8'($urandom_range(255));
      op2 = 8'($urandom_range(255));
      // Branches mostly land on an instruction of the same program.
      if ((opc == bcc_pkg::OP_JMP || opc == bcc_pkg::OP_JEQ) && $urandom_range(3) != 0) begin
        op1 = base + 8'(3 * $urandom_range(n_instr - 1));
      end
      at = base + 8'(3 * i);
      send_command(bcc_pkg::CMD_WRITE, at, opc);
      send_command(bcc_pkg::CMD_WRITE, at + 8'd1, op1);
      send_command(bcc_pkg::CMD_WRITE, at + 8'd2, op2);
    end
    send_command(bcc_pkg::CMD_RESTART, base, 8'($urandom_range(255)));
    n_steps = n_instr + $urandom_range(0, 3);
    for (int i = 0; i < n_steps; i++) begin
      send_command(bcc_pkg::CMD_STEP, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if ($urandom_range(5) == 0) begin
        send_command(bcc_pkg::CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    cpu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with no command outstanding, actual tdata 0x%0h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 8'(want.status), 8'(m_axis_tuser[1:0]));
        compare_field("print_valid", 8'(want.prn_valid), 8'(m_axis_tuser[2]));
        compare_field("pc_out", want.pc, m_axis_tdata[7:0]);
        compare_field("opcode", want.opcode, m_axis_tdata[15:8]);
        compare_field("print_reg", 8'(want.prn_reg), 8'(m_axis_tdata[17:16]));
        compare_field("print_value", want.prn_value, m_axis_tdata[25:18]);
        compare_field("read_data", want.rd_data, m_axis_tdata[33:26]);
        compare_field("zero_out", 8'(want.zero), 8'(m_axis_tdata[34]));
        compare_field("tdata padding", 8'd0, 8'(m_axis_tdata[39:35]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("byte_code_cpu_step test failed");
      $finish;
    end
  end

  initial begin : stimulus
    cpu_result_t golden;
    int          idle_plan [4];
    int          stall_plan [4];
    idle_plan  = '{0, 58, 0, 38};
    stall_plan = '{0, 0, 58, 38};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      golden         = '0;
      golden.status  = DirectedRows[i].status;
      golden.pc      = DirectedRows[i].pc;
      golden.opcode  = DirectedRows[i].opcode;
      golden.rd_data = DirectedRows[i].rd_data;
      send_command(DirectedRows[i].cmd, DirectedRows[i].addr, DirectedRows[i].data,
                   DirectedRows[i].typed, golden);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      while (items_fed < (p + 1) * ItemsPerPhase) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_command(bcc_pkg::cmd_e'($urandom_range(3)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
          end
        end else begin
          run_program();
        end
      end
      // Let the block drain completely before the next phase starts.
      idle_bus();
      while (pending_results.size() != 0) @(posedge clk_i);
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("Ran %0d commands in four handshake phases: %0d ok, %0d halts, %0d stops on",
             items_fed, status_count[bcc_pkg::ST_OK], status_count[bcc_pkg::ST_HALTED],
             status_count[bcc_pkg::ST_UNKNOWN]);
    $display("unknown opcodes, %0d steps while stopped and %0d prints.",
             status_count[bcc_pkg::ST_STOPPED], print_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("byte_code_cpu_step test passed");
    end else begin
      $display("byte_code_cpu_step test failed");
    end
    $finish;
  end

endmodule
